[src/lscc_pkg.sv]
// Shared constants, types and tables of the laser scan cluster centroid block.
// No dependencies; every other file imports this package.
package lscc_pkg;

	localparam int RANGE_BITS     = 16;
	localparam int ANGLE_BITS     = 16;
	localparam int TRIG_FRAC_BITS = 15;
	localparam int RUN_COUNT_BITS = 6;

	localparam int COUNT_BITS   = 10;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int CENT_W       = 17;

	localparam int CORDIC_STEPS = 24;
	localparam int STEP_BITS    = 5;
	localparam int CW           = 33;          // CORDIC datapath, 30 fraction bits
	localparam int TRIG_SH      = 30 - TRIG_FRAC_BITS;
	localparam int TRIG_W       = TRIG_FRAC_BITS + 3;
	localparam int PROD_W       = RANGE_BITS + 1 + TRIG_W;
	localparam int XI_W         = RANGE_BITS + 2;
	localparam int SUM_BITS     = XI_W + RUN_COUNT_BITS;
	localparam int NUM_W        = SUM_BITS + 1;
	localparam int DEN_W        = RUN_COUNT_BITS + 1;
	localparam int DIV_CNT_BITS = $clog2(NUM_W);

	localparam logic signed [CW-1:0] CORDIC_GAIN_INV = CW'(652032874);
	localparam logic [RANGE_BITS-1:0] NO_RETURN = {RANGE_BITS{1'b1}};
	localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = {RUN_COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_JUMP_LIMIT  = 3'd0,
		REG_MAX_RANGE   = 3'd1,
		REG_MIN_POINTS  = 3'd2,
		REG_MAX_POINTS  = 3'd3,
		REG_ANGLE_START = 3'd4,
		REG_ANGLE_STEP  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RANGE_BITS-1:0]     jump_limit_mm;
		logic [RANGE_BITS-1:0]     max_range_mm;
		logic [RUN_COUNT_BITS-1:0] min_points;
		logic [RUN_COUNT_BITS-1:0] max_points;
		logic [ANGLE_BITS-1:0]     angle_start;
		logic [ANGLE_BITS-1:0]     angle_step;
	} cfg_t;

	// classified sample handed from front to back
	typedef struct packed {
		logic [RANGE_BITS-1:0] range;
		logic [ANGLE_BITS-1:0] angle;
		logic                  joins;
		logic                  start;
		logic                  last;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CORDIC,
		BK_MULX,
		BK_MULY,
		BK_UPDATE,
		BK_DIVIDE,
		BK_EMIT
	} back_state_t;

	// arctangent of 2^-i, 2^32 units per turn
	function automatic logic signed [CW-1:0] atan_turn(input logic [STEP_BITS-1:0] i);
		logic signed [CW-1:0] v;
		case (i)
			5'd0:  v = CW'(536870912);
			5'd1:  v = CW'(316933406);
			5'd2:  v = CW'(167458907);
			5'd3:  v = CW'(85004756);
			5'd4:  v = CW'(42667331);
			5'd5:  v = CW'(21354465);
			5'd6:  v = CW'(10679838);
			5'd7:  v = CW'(5340245);
			5'd8:  v = CW'(2670163);
			5'd9:  v = CW'(1335087);
			5'd10: v = CW'(667544);
			5'd11: v = CW'(333772);
			5'd12: v = CW'(166886);
			5'd13: v = CW'(83443);
			5'd14: v = CW'(41722);
			5'd15: v = CW'(20861);
			5'd16: v = CW'(10431);
			5'd17: v = CW'(5215);
			5'd18: v = CW'(2608);
			5'd19: v = CW'(1304);
			5'd20: v = CW'(652);
			5'd21: v = CW'(326);
			5'd22: v = CW'(163);
			5'd23: v = CW'(81);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[src/lscc_if.sv]
// Channel interfaces: sample input, cluster result output, configuration write.
// Depends on lscc_pkg.
interface lscc_in_if;
	import lscc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [RANGE_BITS-1:0] range_mm;
	logic                  scan_last;
	modport source (output valid, range_mm, scan_last, input ready);
	modport sink (input valid, range_mm, scan_last, output ready);
endinterface

interface lscc_out_if;
	import lscc_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [CENT_W-1:0]      centroid_x;
	logic signed [CENT_W-1:0]      centroid_y;
	logic [RUN_COUNT_BITS-1:0]     point_count;
	logic                          cluster_valid;
	logic                          scan_end;
	logic [COUNT_BITS-1:0]         clusters_in_scan;
	modport source (output valid, centroid_x, centroid_y, point_count, cluster_valid,
		scan_end, clusters_in_scan, input ready);
	modport sink (input valid, centroid_x, centroid_y, point_count, cluster_valid,
		scan_end, clusters_in_scan, output ready);
endinterface

interface lscc_cfg_if;
	import lscc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[src/lscc_front.sv]
// Front end: takes samples, tracks previous range and sample angle, decides joins.
// Depends on lscc_pkg and lscc_if.
module lscc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lscc_in_if.sink              sample,
	input  lscc_pkg::cfg_t       cfg,
	input  logic                 q_full,
	output logic                 q_push,
	output lscc_pkg::item_t      q_item
);
	import lscc_pkg::*;

	logic                  start_q;
	logic [RANGE_BITS-1:0] prev_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] angle;
	logic [RANGE_BITS-1:0] diff;

	assign sample.ready = !q_full;
	assign q_push = sample.valid && !q_full;
	assign angle = start_q ? cfg.angle_start : angle_q;
	assign diff = (sample.range_mm > prev_q) ? sample.range_mm - prev_q
		: prev_q - sample.range_mm;

	always_comb begin
		q_item.range = sample.range_mm;
		q_item.angle = angle;
		q_item.start = start_q;
		q_item.last = sample.scan_last;
		q_item.joins = !start_q && sample.range_mm != NO_RETURN && prev_q != NO_RETURN &&
			diff < cfg.jump_limit_mm && sample.range_mm <= cfg.max_range_mm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			prev_q <= '0;
			angle_q <= '0;
		end else if (q_push) begin
			start_q <= sample.scan_last;
			prev_q <= sample.range_mm;
			angle_q <= angle + cfg.angle_step;
		end
	end

endmodule

[src/lscc_queue.sv]
// Two-entry request queue between front and back ends.
// Depends on lscc_pkg.
module lscc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lscc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output lscc_pkg::item_t head
);
	import lscc_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[src/lscc_back.sv]
// Back end: CORDIC trig, per-sample projection, run accumulation, serial
// rounding divide and the result register. Depends on lscc_pkg and lscc_if.
module lscc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lscc_pkg::cfg_t  cfg,
	input  logic            q_empty,
	input  lscc_pkg::item_t q_head,
	output logic            q_pop,
	lscc_out_if.source      result
);
	import lscc_pkg::*;

	back_state_t state_q, state_d;

	item_t                     item_q;
	logic signed [CW-1:0]      cx_q, cy_q, cz_q;
	logic [STEP_BITS-1:0]      step_q;
	logic [1:0]                quad_q;
	logic signed [XI_W-1:0]    xi_q, yi_q;

	logic [RUN_COUNT_BITS-1:0] len_q;
	logic                      ovf_q;
	logic signed [SUM_BITS-1:0] sx_q, sy_q;
	logic [COUNT_BITS-1:0]     cnt_q;

	logic [NUM_W-1:0]          nx_q, ny_q;
	logic [DEN_W-1:0]          rx_q, ry_q, den_q;
	logic [DIV_CNT_BITS-1:0]   dcnt_q;
	logic                      negx_q, negy_q, have_q;
	logic [RUN_COUNT_BITS-1:0] pts_q;
	logic [COUNT_BITS-1:0]     clus_q;

	logic                      res_valid_q;

	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(CORDIC_STEPS - 1);
	localparam logic [DIV_CNT_BITS-1:0] LAST_DIV = DIV_CNT_BITS'(NUM_W - 1);

	function automatic logic qualifies(input logic [RUN_COUNT_BITS-1:0] n, input logic o,
		input cfg_t c);
		return n != '0 && !o && n >= c.min_points && n <= c.max_points;
	endfunction

	// ---- combinational helpers ----
	logic [31:0]              a32;
	logic [29:0]              a_low;
	logic signed [CW-1:0]     dx, dy;
	logic signed [CW-1:0]     xr_full, yr_full;
	logic signed [TRIG_W-1:0] xr, yr;
	logic signed [TRIG_W-1:0] cos_v, sin_v;
	logic signed [PROD_W-1:0] prod;
	logic signed [XI_W-1:0]   xi_new;

	assign a32 = {q_head.angle, {(32 - ANGLE_BITS){1'b0}}};
	assign a_low = a32[29:0];
	assign dx = cy_q >>> step_q;
	assign dy = cx_q >>> step_q;
	assign xr_full = (cx_q + (CW'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
	assign yr_full = (cy_q + (CW'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
	assign xr = xr_full[TRIG_W-1:0];
	assign yr = yr_full[TRIG_W-1:0];

	// CORDIC vector is final once the loop is done; map back to the quadrant
	always_comb begin
		case (quad_q)
			2'd0: begin cos_v = xr;  sin_v = yr;  end
			2'd1: begin cos_v = -yr; sin_v = xr;  end
			2'd2: begin cos_v = -xr; sin_v = -yr; end
			default: begin cos_v = yr; sin_v = -xr; end
		endcase
	end

	assign prod = $signed({1'b0, item_q.range}) *
		((state_q == BK_MULX) ? cos_v : sin_v);
	assign xi_new = XI_W'((prod + (PROD_W'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS);

	// run update
	logic                       close_a, close_b, have;
	logic [RUN_COUNT_BITS-1:0]  nlen;
	logic                       novf;
	logic signed [SUM_BITS-1:0] nsx, nsy, dsx, dsy;
	logic [RUN_COUNT_BITS-1:0]  dn;
	logic [SUM_BITS-1:0]        magx, magy;
	logic [COUNT_BITS-1:0]      cnt_next;

	always_comb begin
		if (item_q.joins) begin
			if (len_q >= RUN_MAX) begin
				nlen = len_q;
				novf = 1'b1;
				nsx = sx_q;
				nsy = sy_q;
			end else begin
				nlen = len_q + 1'b1;
				novf = ovf_q;
				nsx = sx_q + SUM_BITS'(xi_q);
				nsy = sy_q + SUM_BITS'(yi_q);
			end
		end else begin
			nlen = RUN_COUNT_BITS'(1);
			novf = 1'b0;
			nsx = SUM_BITS'(xi_q);
			nsy = SUM_BITS'(yi_q);
		end
		close_a = !item_q.start && !item_q.joins && qualifies(len_q, ovf_q, cfg);
		close_b = item_q.last && !close_a && qualifies(nlen, novf, cfg);
		have = close_a || close_b;
		dsx = close_a ? sx_q : nsx;
		dsy = close_a ? sy_q : nsy;
		dn = close_a ? len_q : nlen;
		magx = dsx[SUM_BITS-1] ? SUM_BITS'(-dsx) : SUM_BITS'(dsx);
		magy = dsy[SUM_BITS-1] ? SUM_BITS'(-dsy) : SUM_BITS'(dsy);
		cnt_next = (have && cnt_q < COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	end

	// one restoring divide step for each axis
	logic [DEN_W:0] tx, ty;
	logic           bx, by;
	always_comb begin
		tx = {rx_q, nx_q[NUM_W-1]};
		ty = {ry_q, ny_q[NUM_W-1]};
		bx = tx >= {1'b0, den_q};
		by = ty >= {1'b0, den_q};
	end

	logic out_free;
	assign out_free = !res_valid_q || result.ready;

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					state_d = BK_CORDIC;
				end
			end
			BK_CORDIC: if (step_q == LAST_STEP) state_d = BK_MULX;
			BK_MULX: state_d = BK_MULY;
			BK_MULY: state_d = BK_UPDATE;
			BK_UPDATE: begin
				if (have) state_d = BK_DIVIDE;
				else if (item_q.last) state_d = BK_EMIT;
				else state_d = BK_IDLE;
			end
			BK_DIVIDE: if (dcnt_q == LAST_DIV) state_d = BK_EMIT;
			BK_EMIT: if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// ---- datapath ----
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				item_q <= q_head;
				step_q <= '0;
				cx_q <= CORDIC_GAIN_INV;
				cy_q <= '0;
				if (a_low >= 30'h2000_0000) begin
					cz_q <= $signed({3'b000, a_low}) - CW'(33'sh4000_0000);
					quad_q <= a32[31:30] + 2'd1;
				end else begin
					cz_q <= $signed({3'b000, a_low});
					quad_q <= a32[31:30];
				end
			end
			BK_CORDIC: begin
				step_q <= step_q + 1'b1;
				if (!cz_q[CW-1]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - atan_turn(step_q);
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + atan_turn(step_q);
				end
			end
			BK_MULX: xi_q <= xi_new;
			BK_MULY: yi_q <= xi_new;
			BK_UPDATE: begin
				have_q <= have;
				pts_q <= have ? dn : '0;
				clus_q <= cnt_next;
				negx_q <= dsx[SUM_BITS-1];
				negy_q <= dsy[SUM_BITS-1];
				nx_q <= {magx, 1'b0} + NUM_W'(dn);
				ny_q <= {magy, 1'b0} + NUM_W'(dn);
				den_q <= {dn, 1'b0};
				rx_q <= '0;
				ry_q <= '0;
				dcnt_q <= '0;
			end
			BK_DIVIDE: begin
				dcnt_q <= dcnt_q + 1'b1;
				rx_q <= bx ? DEN_W'(tx - {1'b0, den_q}) : tx[DEN_W-1:0];
				ry_q <= by ? DEN_W'(ty - {1'b0, den_q}) : ty[DEN_W-1:0];
				nx_q <= {nx_q[NUM_W-2:0], bx};
				ny_q <= {ny_q[NUM_W-2:0], by};
			end
			default: ;
		endcase
	end

	// run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			sx_q <= '0;
			sy_q <= '0;
			cnt_q <= '0;
		end else if (state_q == BK_UPDATE) begin
			sx_q <= nsx;
			sy_q <= nsy;
			if (item_q.last) begin
				len_q <= '0;
				ovf_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				len_q <= nlen;
				ovf_q <= novf;
				cnt_q <= cnt_next;
			end
		end
	end

	// result register
	logic load_out;
	assign load_out = state_q == BK_EMIT && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (load_out) res_valid_q <= 1'b1;
		else if (result.ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result.centroid_x <= have_q ? (negx_q ? -CENT_W'(nx_q) : CENT_W'(nx_q)) : '0;
			result.centroid_y <= have_q ? (negy_q ? -CENT_W'(ny_q) : CENT_W'(ny_q)) : '0;
			result.point_count <= pts_q;
			result.cluster_valid <= have_q;
			result.scan_end <= item_q.last;
			result.clusters_in_scan <= clus_q;
		end
	end

	assign result.valid = res_valid_q;

`ifndef SYNTHESIS
	a_last_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_UPDATE && item_q.last) |=> (len_q == '0 && cnt_q == '0))
		else $error("run state not cleared after scan end");
	a_cluster_has_points: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && have_q) |-> (pts_q != '0))
		else $error("cluster emitted with no points");
	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == BK_IDLE && !q_empty))
		else $error("queue popped while back end busy");
	a_emit_only_when_caused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_UPDATE && !have && !item_q.last) |=> state_q == BK_IDLE)
		else $error("result started for a sample that causes none");
`endif

endmodule

[src/laser_scan_cluster_centroid.sv]
// Top level: configuration registers, front end, request queue, back end.
// Depends on lscc_pkg, lscc_if, lscc_front, lscc_queue, lscc_back.
//
//  channel  | modport | payload
//  ---------+---------+-----------------------------------------------------
//  sample   | sink    | range_mm, scan_last
//  result   | source  | centroid_x/y, point_count, cluster_valid, scan_end, ...
//  cfg      | sink    | index, data (always ready)
//
// A sample passes the back end in order: the pop state, 24 CORDIC iterations,
// two multiplies and one update; a sample that ends a scan adds an emit step,
// and one that closes a cluster adds the serial divide and an emit step.
// The front end takes a sample each cycle into a two-entry queue; it stalls
// only when the queue is full. A waiting result holds the back end, and the
// queue then fills and stalls the front end.
// Reset is asynchronous and needs no clearing pass.
module laser_scan_cluster_centroid (
	input  logic       clk,
	input  logic       arst_n,
	lscc_in_if.sink    sample,
	lscc_out_if.source result,
	lscc_cfg_if.sink   cfg
);
	import lscc_pkg::*;

	cfg_t  cfg_q;
	logic  q_full, q_push, q_pop, q_empty;
	item_t push_item, head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jump_limit_mm <= RANGE_BITS'(800);
			cfg_q.max_range_mm <= RANGE_BITS'(3000);
			cfg_q.min_points <= RUN_COUNT_BITS'(3);
			cfg_q.max_points <= RUN_COUNT_BITS'(19);
			cfg_q.angle_start <= '0;
			cfg_q.angle_step <= ANGLE_BITS'(182);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_JUMP_LIMIT:  cfg_q.jump_limit_mm <= cfg.data[RANGE_BITS-1:0];
				REG_MAX_RANGE:   cfg_q.max_range_mm <= cfg.data[RANGE_BITS-1:0];
				REG_MIN_POINTS:  cfg_q.min_points <= cfg.data[RUN_COUNT_BITS-1:0];
				REG_MAX_POINTS:  cfg_q.max_points <= cfg.data[RUN_COUNT_BITS-1:0];
				REG_ANGLE_START: cfg_q.angle_start <= cfg.data[ANGLE_BITS-1:0];
				REG_ANGLE_STEP:  cfg_q.angle_step <= cfg.data[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	lscc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (push_item)
	);

	lscc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (head)
	);

	lscc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_head  (head),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
